// File: src/ekc_pkg.sv
`timescale 1ns / 1ps

package ekc_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KEY_W  = 9;
  localparam int unsigned POS_W  = 10;

  // Decoder-to-cursor queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [POS_W-1:0] ROWS_RESET = POS_W'(24);
  localparam logic [POS_W-1:0] COLS_RESET = POS_W'(80);
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Input bytes
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4f;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7e;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
  localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
  localparam logic [BYTE_W-1:0] CH_4     = 8'h34;
  localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
  localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
  localparam logic [BYTE_W-1:0] CH_7     = 8'h37;
  localparam logic [BYTE_W-1:0] CH_8     = 8'h38;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CTRL_MASK = 8'h1f;
  localparam logic [BYTE_W-1:0] CH_Q     = 8'h71;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_ESC   = 9'd27;
  localparam logic [KEY_W-1:0] KEY_QUIT  = {1'b0, CH_Q & CTRL_MASK};
  localparam logic [KEY_W-1:0] KEY_LEFT  = 9'd256;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 9'd257;
  localparam logic [KEY_W-1:0] KEY_UP    = 9'd258;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 9'd259;
  localparam logic [KEY_W-1:0] KEY_DEL   = 9'd260;
  localparam logic [KEY_W-1:0] KEY_HOME  = 9'd261;
  localparam logic [KEY_W-1:0] KEY_END   = 9'd262;
  localparam logic [KEY_W-1:0] KEY_PGUP  = 9'd263;
  localparam logic [KEY_W-1:0] KEY_PGDN  = 9'd264;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_SEQ   = 2'd2,
    PH_DIGIT = 2'd3
  } parse_phase_e;

  typedef struct packed {
    logic [POS_W-1:0] rows;
    logic [POS_W-1:0] cols;
  } screen_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/ekc_in_if.sv
`timescale 1ns / 1ps

interface ekc_in_if import ekc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              timed_out;

  modport source (output valid, output in_byte, output timed_out, input ready);
  modport sink   (input valid, input in_byte, input timed_out, output ready);
endinterface

// File: src/ekc_out_if.sv
`timescale 1ns / 1ps

interface ekc_out_if import ekc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic             quit_request;
  logic [POS_W-1:0] cursor_col;
  logic [POS_W-1:0] cursor_row;

  modport source (output valid, output key_code, output quit_request,
                  output cursor_col, output cursor_row, input ready);
  modport sink   (input valid, input key_code, input quit_request,
                  input cursor_col, input cursor_row, output ready);
endinterface

// File: src/ekc_front.sv
`timescale 1ns / 1ps

module ekc_front import ekc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              tmo_i,
  output logic              push_o,
  output logic [KEY_W-1:0]  key_o
);

  parse_phase_e      phase_q, phase_d;
  logic [BYTE_W-1:0] lead_q, lead_d;
  logic [BYTE_W-1:0] digit_q, digit_d;
  logic              emit;
  logic [KEY_W-1:0]  key;

  function automatic logic [KEY_W-1:0] decode_letter(logic [BYTE_W-1:0] lead,
                                                     logic [BYTE_W-1:0] b);
    logic [KEY_W-1:0] k;
    k = KEY_ESC;
    if (lead == CH_LBRK) begin
      if      (b == CH_A) k = KEY_UP;
      else if (b == CH_B) k = KEY_DOWN;
      else if (b == CH_C) k = KEY_RIGHT;
      else if (b == CH_D) k = KEY_LEFT;
      else if (b == CH_H) k = KEY_HOME;
      else if (b == CH_F) k = KEY_END;
    end else if (lead == CH_O) begin
      if      (b == CH_H) k = KEY_HOME;
      else if (b == CH_F) k = KEY_END;
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] decode_digit(logic [BYTE_W-1:0] d);
    logic [KEY_W-1:0] k;
    k = KEY_ESC;
    if      (d == CH_1 || d == CH_7) k = KEY_HOME;
    else if (d == CH_3)              k = KEY_DEL;
    else if (d == CH_4 || d == CH_8) k = KEY_END;
    else if (d == CH_5)              k = KEY_PGUP;
    else if (d == CH_6)              k = KEY_PGDN;
    return k;
  endfunction

  always_comb begin
    phase_d = phase_q;
    lead_d  = lead_q;
    digit_d = digit_q;
    emit    = 1'b0;
    key     = KEY_ESC;
    if (tmo_i) begin
      // timeout mid-sequence flushes a bare ESC; idle timeout is silent
      emit    = (phase_q != PH_IDLE);
      phase_d = PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (byte_i == CH_ESC) begin
            phase_d = PH_ESC;
          end else begin
            emit = 1'b1;
            key  = {1'b0, byte_i};
          end
        end
        PH_ESC: begin
          lead_d  = byte_i;
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          if (lead_q == CH_LBRK && byte_i >= CH_0 && byte_i <= CH_9) begin
            digit_d = byte_i;
            phase_d = PH_DIGIT;
          end else begin
            emit    = 1'b1;
            key     = decode_letter(lead_q, byte_i);
            phase_d = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          emit    = 1'b1;
          key     = (byte_i == CH_TILDE) ? decode_digit(digit_q) : KEY_ESC;
          phase_d = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign push_o = accept_i & emit;
  assign key_o  = key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lead_q  <= '0;
      digit_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      digit_q <= digit_d;
    end
  end

endmodule

// File: src/ekc_queue.sv
`timescale 1ns / 1ps

module ekc_queue import ekc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             pop_i,
  output logic [KEY_W-1:0] key_o,
  output q_stat_t          stat_o
);

  logic [KEY_W-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o = '{full: (cnt_q == QCNT_W'(QDEPTH)), empty: (cnt_q == '0)};
  assign key_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= key_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("pop from empty queue");

endmodule

// File: src/ekc_back.sv
`timescale 1ns / 1ps

module ekc_back import ekc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  screen_cfg_t      cfg_i,
  input  logic             key_valid_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KEY_W-1:0] key_o,
  output logic             quit_o,
  output logic [POS_W-1:0] col_o,
  output logic [POS_W-1:0] row_o
);

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic             quit_q;
  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [POS_W:0]   row_inc, col_inc;

  assign pop_o   = key_valid_i & (~valid_q | out_ready_i);
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign col_inc = {1'b0, col_q} + 1'b1;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    unique case (key_i)
      KEY_UP:    if (row_q != '0) row_d = row_q - 1'b1;
      KEY_DOWN:  if (row_inc < {1'b0, cfg_i.rows}) row_d = row_inc[POS_W-1:0];
      KEY_LEFT:  if (col_q != '0) col_d = col_q - 1'b1;
      KEY_RIGHT: if (col_inc < {1'b0, cfg_i.cols}) col_d = col_inc[POS_W-1:0];
      KEY_HOME:  row_d = '0;
      KEY_END:   col_d = (cfg_i.cols == '0) ? '0 : cfg_i.cols - 1'b1;
      KEY_PGUP:  row_d = (row_q > cfg_i.rows) ? row_q - cfg_i.rows : '0;
      KEY_PGDN: begin
        if (cfg_i.rows != '0 && row_q < cfg_i.rows - 1'b1) row_d = cfg_i.rows - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        col_q   <= col_d;
        row_q   <= row_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      key_q  <= key_i;
      quit_q <= (key_i == KEY_QUIT);
    end
  end

  assign out_valid_o = valid_q;
  assign key_o       = key_q;
  assign quit_o      = quit_q;
  assign col_o       = col_q;
  assign row_o       = row_q;

endmodule

// File: src/escape_key_cursor_control.sv
`timescale 1ns / 1ps
// A byte that completes a key is pushed into the queue; the cursor unit then registers it as an output beat.
// Throughput: one beat per cycle while the queue has room; the decoder and the cursor unit run off a 2-entry queue.
// Bytes that open a sequence, and idle timeouts, give no result.
// Reset (rst_ni low, async): parser idle, cursor at 0/0, queue and output empty,
// screen_rows 24, screen_cols 80.

module escape_key_cursor_control import ekc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ekc_in_if.sink             in_i,
  ekc_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Screen size registers; paddr[2] picks the register
  screen_cfg_t cfg_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows <= ROWS_RESET;
      cfg_q.cols <= COLS_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ROWS) cfg_q.rows <= pwdata[POS_W-1:0];
      else                      cfg_q.cols <= pwdata[POS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROWS) ? PDATA_W'(cfg_q.rows) : PDATA_W'(cfg_q.cols);

  // Front: accepts every beat while the queue has room
  q_stat_t          qstat;
  logic             in_accept;
  logic             push;
  logic [KEY_W-1:0] push_key;
  logic             pop;
  logic [KEY_W-1:0] head_key;

  assign in_i.ready = ~qstat.full;
  assign in_accept  = in_i.valid & in_i.ready;

  ekc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_i.in_byte),
    .tmo_i    (in_i.timed_out),
    .push_o   (push),
    .key_o    (push_key)
  );

  // Decoded keys wait here so a stalled output does not stop the parser at once
  ekc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .key_i  (push_key),
    .pop_i  (pop),
    .key_o  (head_key),
    .stat_o (qstat)
  );

  // Back: applies the key to the cursor and registers the result beat
  ekc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .key_valid_i (~qstat.empty),
    .key_i       (head_key),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .key_o       (out_o.key_code),
    .quit_o      (out_o.quit_request),
    .col_o       (out_o.cursor_col),
    .row_o       (out_o.cursor_row)
  );

endmodule

// File: dv/escape_key_cursor_control_test.sv
`timescale 1ns / 1ps

module escape_key_cursor_control_test;
  import ekc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Expected output beat: decoded key plus the cursor after it was applied.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             quit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } key_beat_t;

  // Keeps its own copy of the parser, the cursor and the screen size, and
  // queues the key beat that each input beat should produce.
  class key_cursor_board;
    int unsigned  rows = ROWS_RESET;
    int unsigned  cols = COLS_RESET;
    parse_phase_e phase = PH_IDLE;
    logic [7:0]   lead = '0;
    logic [7:0]   digit = '0;
    int unsigned  col = 0;
    int unsigned  row = 0;
    key_beat_t    pending_keys[$];
    int unsigned  mismatches = 0;
    int unsigned  keys_checked = 0;
    int unsigned  quits_seen = 0;

    task report_mismatch(input string what);
      $display("[%0t] error: %s", $time, what);
      mismatches++;
    endtask

    function void note_byte(input logic [BYTE_W-1:0] b, input logic tmo);
      logic [KEY_W-1:0] key;
      bit               emit;
      emit = 1'b1;
      key  = KEY_ESC;
      if (tmo) begin
        // a timeout only matters inside a sequence; there it gives a bare ESC
        if (phase == PH_IDLE) emit = 1'b0;
        phase = PH_IDLE;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (b == CH_ESC) begin
              phase = PH_ESC;
              emit  = 1'b0;
            end else begin
              key = {1'b0, b};
            end
          end
          PH_ESC: begin
            lead  = b;
            phase = PH_SEQ;
            emit  = 1'b0;
          end
          PH_SEQ: begin
            if (lead == CH_LBRK && b >= CH_0 && b <= CH_9) begin
              digit = b;
              phase = PH_DIGIT;
              emit  = 1'b0;
            end else begin
              phase = PH_IDLE;
              if (lead == CH_LBRK) begin
                case (b)
                  CH_A:    key = KEY_UP;
                  CH_B:    key = KEY_DOWN;
                  CH_C:    key = KEY_RIGHT;
                  CH_D:    key = KEY_LEFT;
                  CH_H:    key = KEY_HOME;
                  CH_F:    key = KEY_END;
                  default: key = KEY_ESC;
                endcase
              end else if (lead == CH_O && b == CH_H) begin
                key = KEY_HOME;
              end else if (lead == CH_O && b == CH_F) begin
                key = KEY_END;
              end
            end
          end
          default: begin
            phase = PH_IDLE;
            if (b == CH_TILDE) begin
              case (digit)
                CH_1, CH_7: key = KEY_HOME;
                CH_3:       key = KEY_DEL;
                CH_4, CH_8: key = KEY_END;
                CH_5:       key = KEY_PGUP;
                CH_6:       key = KEY_PGDN;
                default:    key = KEY_ESC;
              endcase
            end
          end
        endcase
      end
      if (emit) begin
        case (key)
          KEY_UP:    if (row != 0) row--;
          KEY_DOWN:  if (row + 1 < rows) row++;
          KEY_LEFT:  if (col != 0) col--;
          KEY_RIGHT: if (col + 1 < cols) col++;
          KEY_HOME:  row = 0;
          KEY_END:   col = (cols == 0) ? 0 : cols - 1;
          KEY_PGUP:  row = (row > rows) ? row - rows : 0;
          KEY_PGDN:  if (rows != 0 && row < rows - 1) row = rows - 1;
          default: ;
        endcase
        pending_keys.push_back('{key, key == KEY_QUIT, POS_W'(col), POS_W'(row)});
      end
    endfunction

    task check_key(input key_beat_t got);
      key_beat_t exp;
      if (pending_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected key beat key=%0d col=%0d row=%0d",
                                  got.key, got.col, got.row));
      end else begin
        exp = pending_keys.pop_front();
        keys_checked++;
        if (got.quit) quits_seen++;
        if (got.key !== exp.key)
          report_mismatch($sformatf("key_code got %0d exp %0d", got.key, exp.key));
        if (got.quit !== exp.quit)
          report_mismatch($sformatf("quit_request got %0b exp %0b", got.quit, exp.quit));
        if (got.col !== exp.col)
          report_mismatch($sformatf("cursor_col got %0d exp %0d (key %0d)",
                                    got.col, exp.col, exp.key));
        if (got.row !== exp.row)
          report_mismatch($sformatf("cursor_row got %0d exp %0d (key %0d)",
                                    got.row, exp.row, exp.key));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ekc_in_if  in_if ();
  ekc_out_if out_if ();

  escape_key_cursor_control dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  key_cursor_board board = new();

  // Stimulus bookkeeping. useful_beats skips timeouts that hit an idle parser,
  // since the block just drops those.
  int unsigned useful_beats = 0;
  int unsigned settings_run = 0;
  int unsigned cycle_count = 0;
  bit          tx_no_idle = 1'b0;
  bit          rx_no_idle = 1'b0;
  bit          hold_req = 1'b0;

  // Final bytes of the recognized sequences
  localparam logic [7:0] BRACKET_FINALS[6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
  localparam logic [7:0] TILDE_DIGITS[7]   = '{CH_1, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8};

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake or a lost key beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d key beats still pending",
               cycle_count, board.pending_keys.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all in burst stretches.
  function automatic int unsigned pick_gap(input bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side: random back-pressure, plus one long hold-off on request.
  // ready is set at the falling edge, beats are taken at the rising edge.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        board.check_key('{out_if.key_code, out_if.quit_request,
                          out_if.cursor_col, out_if.cursor_row});
        stall_left = pick_gap(rx_no_idle);
      end
    end
  end

  // One input beat: optional idle gap, then hold valid until the block takes it.
  // Returns at the accepting rising edge; the next call or drain moves valid.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic tmo);
    int unsigned gap;
    gap = pick_gap(tx_no_idle);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.in_byte   = b;
    in_if.timed_out = tmo;
    do @(posedge clk_i); while (!in_if.ready);
    if (!(tmo && board.phase == PH_IDLE)) useful_beats++;
    board.note_byte(b, tmo);
  endtask

  // Stop offering input, wait for every queued key beat, then let the clock
  // run on before returning.
  task automatic drain;
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (board.pending_keys.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic wr, input logic idx, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write both screen registers and read each one back.
  task automatic set_screen(input int unsigned nrows, input int unsigned ncols);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, REG_ROWS, PDATA_W'(nrows), rd);
    board.rows = nrows;
    apb_xfer(1'b1, REG_COLS, PDATA_W'(ncols), rd);
    board.cols = ncols;
    apb_xfer(1'b0, REG_ROWS, '0, rd);
    if (rd !== PDATA_W'(nrows))
      board.report_mismatch($sformatf("screen_rows read %0d exp %0d", rd, nrows));
    apb_xfer(1'b0, REG_COLS, '0, rd);
    if (rd !== PDATA_W'(ncols))
      board.report_mismatch($sformatf("screen_cols read %0d exp %0d", rd, ncols));
    settings_run++;
  endtask

  // Random traffic: mostly complete key sequences with random picks, the rest
  // plain bytes, ctrl-Q, stray timeouts and sequences cut short or garbled.
  task automatic send_random(input int unsigned n_beats);
    int unsigned target;
    int unsigned r;
    int unsigned s;
    target = useful_beats + n_beats;
    while (useful_beats < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        s = $urandom_range(0, 14);
        send_beat(CH_ESC, 1'b0);
        if (s < 6) begin
          send_beat(CH_LBRK, 1'b0);
          send_beat(BRACKET_FINALS[s], 1'b0);
        end else if (s < 8) begin
          send_beat(CH_O, 1'b0);
          send_beat((s == 6) ? CH_H : CH_F, 1'b0);
        end else begin
          send_beat(CH_LBRK, 1'b0);
          send_beat(TILDE_DIGITS[s - 8], 1'b0);
          send_beat(CH_TILDE, 1'b0);
        end
      end else if (r < 72) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 77) begin
        send_beat(CH_Q & CTRL_MASK, 1'b0);
      end else if (r < 82) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        s = $urandom_range(0, 4);
        send_beat(CH_ESC, 1'b0);
        case (s)
          0: send_beat(8'($urandom_range(0, 255)), 1'b1);
          1: begin
            send_beat(CH_LBRK, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1);
          end
          2: begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b0);
          end
          3: begin
            send_beat(CH_LBRK, 1'b0);
            send_beat(8'($urandom_range(CH_0, CH_9)), 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b0);
          end
          default: begin
            send_beat(CH_LBRK, 1'b0);
            send_beat(8'($urandom_range(CH_0, CH_9)), 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
      end
    end
  endtask

  // Screen sizes per phase: extremes, a shrink below a cursor that the big
  // screen let wander far out, zero-sized registers, and lopsided shapes.
  int unsigned phase_rows[6] = '{1023, 3, 1, 0, 1023, 1};
  int unsigned phase_cols[6] = '{1023, 2, 1, 0, 1, 1023};

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.in_byte   = '0;
    in_if.timed_out = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats at the reset screen size: byte extremes, quit, an idle
    // timeout, each sequence form, an unknown O sequence, timeouts cutting a
    // sequence after ESC and after ESC [, and an unknown ESC [ digit ~ sequence.
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(CH_Q & CTRL_MASK, 1'b0);
    send_beat(8'hff, 1'b1);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_LBRK, 1'b0);
    send_beat(CH_B, 1'b0);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_LBRK, 1'b0);
    send_beat(CH_6, 1'b0);
    send_beat(CH_TILDE, 1'b0);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_O, 1'b0);
    send_beat(CH_F, 1'b0);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_O, 1'b0);
    send_beat(CH_A, 1'b0);
    send_beat(CH_ESC, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_LBRK, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(CH_ESC, 1'b0);
    send_beat(CH_LBRK, 1'b0);
    send_beat(CH_0, 1'b0);
    send_beat(CH_TILDE, 1'b0);
    send_random(60);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p < 6) set_screen(phase_rows[p], phase_cols[p]);
      else set_screen($urandom_range(1, 1023), $urandom_range(1, 1023));
      // one phase runs back to back with no idling on either side
      tx_no_idle = (p == 2);
      rx_no_idle = (p == 2);
      if (p == 4) begin
        // long receiver hold-off while plain bytes keep coming: the internal
        // queue fills and the input side has to stall
        hold_req = 1'b1;
        tx_no_idle = 1'b1;
        repeat (24) send_beat(8'($urandom_range(CH_A, CH_Q)), 1'b0);
        tx_no_idle = 1'b0;
      end
      send_random(55);
      drain();
    end

    repeat (8) @(posedge clk_i);
    while (board.pending_keys.size() != 0) begin
      key_beat_t left;
      left = board.pending_keys.pop_front();
      board.report_mismatch($sformatf("key %0d never came out", left.key));
    end
    $display("Covered %0d input beats over %0d screen settings plus reset size;",
             useful_beats, settings_run);
    $display("checked %0d key beats (%0d quit) in %0d cycles.",
             board.keys_checked, board.quits_seen, cycle_count);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ekc_pkg.sv
src/ekc_in_if.sv
src/ekc_out_if.sv
src/ekc_front.sv
src/ekc_queue.sv
src/ekc_back.sv
src/escape_key_cursor_control.sv
dv/escape_key_cursor_control_test.sv
